[rtl/mecanum_velocity_mixer_top_defines.svh]
// Assertion macros shared by the mixer RTL.
`ifndef MECANUM_VELOCITY_MIXER_TOP_DEFINES_SVH
`define MECANUM_VELOCITY_MIXER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define MVM_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define MVM_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/mvm_pkg.sv]
// Types, constants, microcode and tables for the mecanum velocity mixer.
`timescale 1ns / 1ps

package mvm_pkg;

   // Port widths
   localparam int REQ_DATA_W = 48;   // move_vx, move_vy, move_omega
   localparam int REQ_USER_W = 4;    // cmd
   localparam int RSP_DATA_W = 64;   // four wheel speeds
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Datapath widths
   localparam int V_W     = 16;     // Q3.12 velocities
   localparam int WHEEL_W = 16;     // Q7.8 wheel speeds
   localparam int LO_W    = 30;     // lever_arm * omega, Q24
   localparam int SUM_W   = 31;     // per-wheel Q24 sum
   localparam int PROD_W  = 40;     // sum * inverse_radius
   localparam int CNT_W   = 3;      // wheel loop pass counter

   // Command codes
   localparam logic [3:0] CMD_CLEAR      = 4'd0;
   localparam logic [3:0] CMD_FWD        = 4'd1;
   localparam logic [3:0] CMD_BACK       = 4'd2;
   localparam logic [3:0] CMD_TURN_L     = 4'd3;
   localparam logic [3:0] CMD_TURN_R     = 4'd4;
   localparam logic [3:0] CMD_STRAFE_L   = 4'd5;
   localparam logic [3:0] CMD_STRAFE_R   = 4'd6;
   localparam logic [3:0] CMD_STEP_VX_UP = 4'd7;
   localparam logic [3:0] CMD_STEP_VX_DN = 4'd8;
   localparam logic [3:0] CMD_STEP_OM_UP = 4'd9;
   localparam logic [3:0] CMD_STEP_OM_DN = 4'd10;
   localparam logic [3:0] CMD_STEP_VY_UP = 4'd11;
   localparam logic [3:0] CMD_STEP_VY_DN = 4'd12;
   localparam logic [3:0] CMD_DIRECT     = 4'd13;

   // Register indexes
   localparam logic [2:0] REG_SPEED_STEP   = 3'd0;
   localparam logic [2:0] REG_SPEED_LIMIT  = 3'd1;
   localparam logic [2:0] REG_PRESET_SPEED = 3'd2;
   localparam logic [2:0] REG_INV_RADIUS   = 3'd3;
   localparam logic [2:0] REG_LEVER_ARM    = 3'd4;

   // Register reset values
   localparam logic [12:0] SPEED_STEP_RST   = 13'd205;
   localparam logic [14:0] SPEED_LIMIT_RST  = 15'd1229;
   localparam logic [14:0] PRESET_SPEED_RST = 15'd1024;
   localparam logic [7:0]  INV_RADIUS_RST   = 8'd20;
   localparam logic [12:0] LEVER_ARM_RST    = 13'd1581;

   // Microprogram addresses
   typedef logic [2:0] uaddr_type;
   localparam uaddr_type UA_CLEAR  = 3'd0;
   localparam uaddr_type UA_PRESET = 3'd1;
   localparam uaddr_type UA_STEP   = 3'd2;
   localparam uaddr_type UA_LEVER  = 3'd3;
   localparam uaddr_type UA_LOOP   = 3'd4;
   localparam uaddr_type UA_EMIT   = 3'd5;

   // Last pass of the wheel loop
   localparam logic [CNT_W-1:0] LOOP_LAST = 3'd4;

   typedef enum logic [1:0] {
      SRC_ZERO   = 2'd0,
      SRC_PRESET = 2'd1,
      SRC_MIX    = 2'd2
   } emit_src_type;

   typedef enum logic {
      JC_NONE      = 1'b0,
      JC_LOOP_MORE = 1'b1
   } jump_cond_type;

   // One control word
   typedef struct packed {
      logic          last;
      logic          emit;
      emit_src_type  emit_src;
      logic          clr_state;
      logic          step_en;    // step one stored velocity, reload operands
      logic          lever_en;   // lever_arm * omega
      logic          loop_en;    // sum / gain multiply / round pass
      jump_cond_type jump_cond;
      uaddr_type     jump_target;
   } ucode_type;

   // Sequencer inputs
   typedef struct packed {
      logic      start;
      uaddr_type start_addr;
      logic      advance;
      logic      loop_more;
   } seq_ctl_type;

   // Sequencer outputs
   typedef struct packed {
      logic      busy;
      ucode_type uc;
   } seq_stat_type;

   function automatic ucode_type ucode_rom(input uaddr_type a);
      ucode_type u;
      u = '0;
      u.emit_src    = SRC_ZERO;
      u.jump_cond   = JC_NONE;
      u.jump_target = UA_CLEAR;
      case (a)
         UA_CLEAR: begin
            u.clr_state = 1'b1;
            u.emit      = 1'b1;
            u.emit_src  = SRC_ZERO;
            u.last      = 1'b1;
         end
         UA_PRESET: begin
            u.emit     = 1'b1;
            u.emit_src = SRC_PRESET;
            u.last     = 1'b1;
         end
         UA_STEP: begin
            u.step_en = 1'b1;
         end
         UA_LEVER: begin
            u.lever_en = 1'b1;
         end
         UA_LOOP: begin
            u.loop_en     = 1'b1;
            u.jump_cond   = JC_LOOP_MORE;
            u.jump_target = UA_LOOP;
         end
         UA_EMIT: begin
            u.emit     = 1'b1;
            u.emit_src = SRC_MIX;
            u.last     = 1'b1;
         end
         default: begin
            u.last = 1'b1;
         end
      endcase
      return u;
   endfunction

   // Sign pattern per wheel: {vy negated, lever term negated}
   function automatic logic [1:0] wheel_signs(input logic [1:0] w);
      logic [1:0] s;
      case (w)
         2'd0:    s = 2'b00;   // front left:  x + y + lo
         2'd1:    s = 2'b11;   // front right: x - y - lo
         2'd2:    s = 2'b10;   // rear left:   x - y + lo
         2'd3:    s = 2'b01;   // rear right:  x + y - lo
         default: s = 2'b00;
      endcase
      return s;
   endfunction

   // Preset wheel pattern, bit k set = wheel k runs backwards
   function automatic logic [3:0] preset_neg(input logic [3:0] cmd);
      logic [3:0] m;
      case (cmd)
         CMD_BACK:     m = 4'b1111;
         CMD_TURN_L:   m = 4'b0101;
         CMD_TURN_R:   m = 4'b1010;
         CMD_STRAFE_L: m = 4'b0110;
         CMD_STRAFE_R: m = 4'b1001;
         default:      m = 4'b0000;
      endcase
      return m;
   endfunction

endpackage

[rtl/mvm_seq.sv]
// Microprogram sequencer: step counter, control store and jump logic.
`timescale 1ns / 1ps

module mvm_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  mvm_pkg::seq_ctl_type  ctl,
   output mvm_pkg::seq_stat_type stat
);
   import mvm_pkg::*;

   uaddr_type pc_ff, pc_in;
   logic      busy_ff, busy_in;
   ucode_type uc;
   logic      jump_taken;

   assign uc         = ucode_rom(pc_ff);
   assign jump_taken = (uc.jump_cond == JC_LOOP_MORE) && ctl.loop_more;

   always_comb begin
      pc_in   = pc_ff;
      busy_in = busy_ff;
      if (ctl.start) begin
         pc_in   = ctl.start_addr;
         busy_in = 1'b1;
      end else if (busy_ff && ctl.advance) begin
         if (uc.last) begin
            busy_in = 1'b0;
         end else if (jump_taken) begin
            pc_in = uc.jump_target;
         end else begin
            pc_in = uaddr_type'(pc_ff + 3'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= UA_CLEAR;
         busy_ff <= 1'b0;
      end else begin
         pc_ff   <= pc_in;
         busy_ff <= busy_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.uc   = busy_ff ? uc : ucode_type'('0);

endmodule

[rtl/mecanum_velocity_mixer_top.sv]
// Top level of the mecanum velocity mixer: ports, registers and mixing datapath.
`timescale 1ns / 1ps
//
//  Channel  Dir  Payload                                            Handshake
//  req      in   tuser: cmd; tdata: move_vx, move_vy, move_omega    req_tvalid/req_tready
//  rsp      out  tdata: wheel FL, FR, RL, RR (Q7.8, saturated)       rsp_tvalid/rsp_tready
//  csr      in   csr_index (register), csr_data (value)             csr_valid/csr_ready
//
//  From acceptance to result: clear and presets run the emit step alone, a direct
//  move runs the lever-arm multiply, five passes of the wheel loop through the one
//  gain multiplier, then the emit step, and step commands run a step before these.
//  The next command is taken in the cycle after the emit step.
//  Reset is synchronous: registers return to defaults, stored velocities to zero.
//  A finished result sits in the output register; the program only waits at its
//  emit step while that register holds a transaction not yet taken.
//  Commands 14 and 15 are accepted and dropped without a result.

`include "mecanum_velocity_mixer_top_defines.svh"

module mecanum_velocity_mixer_top (
   input  logic                            clock,
   input  logic                            reset,
   // command stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [mvm_pkg::REQ_DATA_W-1:0]  req_tdata,   // move_vx, move_vy, move_omega
   input  logic [mvm_pkg::REQ_USER_W-1:0]  req_tuser,   // cmd
   // wheel speed stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [mvm_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // front left, front right,
                                                        // rear left, rear right
   // register writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mvm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mvm_pkg::CSR_DATA_W-1:0]  csr_data
);
   import mvm_pkg::*;

   // Round Q24 product to Q8 (half up, floor) and saturate to 16 bits
   function automatic logic signed [WHEEL_W-1:0] round_sat(
      input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] b;
      logic signed [PROD_W-17:0] r;
      b = p + PROD_W'(32768);
      r = b[PROD_W-1:16];
      if (r > (PROD_W-16)'(32767)) begin
         return 16'sh7fff;
      end else if (r < -(PROD_W-16)'(32768)) begin
         return 16'sh8000;
      end else begin
         return r[WHEEL_W-1:0];
      end
   endfunction

   // Handshakes
   logic req_fire, rsp_fire, csr_fire, emit_fire, adv;

   // Configuration registers
   logic [12:0] step_ff, step_in;
   logic [14:0] limit_ff, limit_in;
   logic [14:0] preset_ff, preset_in;
   logic [7:0]  ir_ff, ir_in;
   logic [12:0] lever_ff, lever_in;

   // Command and state
   logic [3:0] cmd_ff, cmd_in;
   logic signed [V_W-1:0] stored_vx_ff, stored_vx_in;
   logic signed [V_W-1:0] stored_vy_ff, stored_vy_in;
   logic signed [V_W-1:0] stored_om_ff, stored_om_in;
   logic signed [V_W-1:0] opnd_vx_ff, opnd_vx_in;
   logic signed [V_W-1:0] opnd_vy_ff, opnd_vy_in;
   logic signed [V_W-1:0] opnd_om_ff, opnd_om_in;

   // Mixing datapath
   logic signed [LO_W-1:0]   lo_ff, lo_in;
   logic signed [SUM_W-1:0]  acc_ff, acc_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [2:0][WHEEL_W-1:0]  wheel_ff, wheel_in;
   logic signed [WHEEL_W-1:0] rnd;

   // Result register
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Sequencer
   seq_ctl_type  seq_ctl;
   seq_stat_type seq_stat;
   ucode_type    uc;

   // Step unit
   logic signed [V_W-1:0] step_cur, stepped;
   logic signed [17:0]    step_wide, step_ext, lim_ext, step_sum, step_diff;

   // Emit
   logic [3:0]               pmask;
   logic [WHEEL_W-1:0]       p16, n16;
   logic [3:0][WHEEL_W-1:0]  emit_w;

   // Wheel loop
   logic [1:0]            sgn;
   logic [1:0]            wr_idx;
   logic signed [SUM_W-1:0] x_ext, y_ext, lo_ext;

   logic cmd_valid;

   assign uc         = seq_stat.uc;
   assign req_tready = !seq_stat.busy;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid_ff && rsp_tready;
   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid && csr_ready;
   // stall only at the emit step, while the result register is still full
   assign adv        = seq_stat.busy && !(uc.emit && rsp_tvalid_ff && !rsp_tready);
   assign emit_fire  = adv && uc.emit;
   assign cmd_valid  = req_tuser <= CMD_DIRECT;

   // Dispatch: first microprogram step from the command code
   always_comb begin
      seq_ctl.start      = req_fire && cmd_valid;
      seq_ctl.start_addr = UA_PRESET;
      seq_ctl.advance    = adv;
      seq_ctl.loop_more  = cnt_ff != LOOP_LAST;
      if (req_tuser == CMD_CLEAR) begin
         seq_ctl.start_addr = UA_CLEAR;
      end else if (req_tuser inside {[CMD_STEP_VX_UP:CMD_STEP_VY_DN]}) begin
         seq_ctl.start_addr = UA_STEP;
      end else if (req_tuser == CMD_DIRECT) begin
         seq_ctl.start_addr = UA_LEVER;
      end
   end

   mvm_seq u_seq (
      .clock (clock),
      .reset (reset),
      .ctl   (seq_ctl),
      .stat  (seq_stat)
   );

   // Register writes
   always_comb begin
      step_in   = step_ff;
      limit_in  = limit_ff;
      preset_in = preset_ff;
      ir_in     = ir_ff;
      lever_in  = lever_ff;
      if (csr_fire) begin
         case (csr_index)
            REG_SPEED_STEP:   step_in   = csr_data[12:0];
            REG_SPEED_LIMIT:  limit_in  = csr_data[14:0];
            REG_PRESET_SPEED: preset_in = csr_data[14:0];
            REG_INV_RADIUS:   ir_in     = csr_data[7:0];
            REG_LEVER_ARM:    lever_in  = csr_data[12:0];
            default: ;
         endcase
      end
   end

   // Step unit: one stored velocity, clamped on the side of the step only
   always_comb begin
      case (cmd_ff)
         CMD_STEP_VX_UP, CMD_STEP_VX_DN: step_cur = stored_vx_ff;
         CMD_STEP_OM_UP, CMD_STEP_OM_DN: step_cur = stored_om_ff;
         default:                        step_cur = stored_vy_ff;
      endcase
      step_wide = 18'(step_cur);
      step_ext  = $signed({5'b0, step_ff});
      lim_ext   = $signed({3'b0, limit_ff});
      step_sum  = step_wide + step_ext;
      step_diff = step_wide - step_ext;
      // odd step codes go up
      if (cmd_ff[0]) begin
         stepped = (step_sum > lim_ext) ? lim_ext[V_W-1:0] : step_sum[V_W-1:0];
      end else begin
         stepped = (step_diff < -lim_ext) ? V_W'(-lim_ext) : step_diff[V_W-1:0];
      end
   end

   // Stored state and operands
   always_comb begin
      cmd_in       = req_fire ? req_tuser : cmd_ff;
      stored_vx_in = stored_vx_ff;
      stored_vy_in = stored_vy_ff;
      stored_om_in = stored_om_ff;
      if (adv && uc.clr_state) begin
         stored_vx_in = '0;
         stored_vy_in = '0;
         stored_om_in = '0;
      end else if (adv && uc.step_en) begin
         case (cmd_ff)
            CMD_STEP_VX_UP, CMD_STEP_VX_DN: stored_vx_in = stepped;
            CMD_STEP_OM_UP, CMD_STEP_OM_DN: stored_om_in = stepped;
            default:                        stored_vy_in = stepped;
         endcase
      end
      opnd_vx_in = opnd_vx_ff;
      opnd_vy_in = opnd_vy_ff;
      opnd_om_in = opnd_om_ff;
      if (seq_ctl.start && (req_tuser == CMD_DIRECT)) begin
         opnd_vx_in = req_tdata[15:0];
         opnd_vy_in = req_tdata[31:16];
         opnd_om_in = req_tdata[47:32];
      end else if (adv && uc.step_en) begin
         opnd_vx_in = stored_vx_in;
         opnd_vy_in = stored_vy_in;
         opnd_om_in = stored_om_in;
      end
   end

   // Wheel loop: pass n sums wheel n, multiplies wheel n-1, rounds wheel n-2
   assign rnd    = round_sat(prod_ff);
   assign sgn    = wheel_signs(cnt_ff[1:0]);
   assign x_ext  = {{3{opnd_vx_ff[V_W-1]}}, opnd_vx_ff, 12'b0};
   assign y_ext  = {{3{opnd_vy_ff[V_W-1]}}, opnd_vy_ff, 12'b0};
   assign lo_ext = SUM_W'(lo_ff);
   assign wr_idx = 2'(cnt_ff - 3'd2);

   always_comb begin
      lo_in    = lo_ff;
      acc_in   = acc_ff;
      prod_in  = prod_ff;
      cnt_in   = cnt_ff;
      wheel_in = wheel_ff;
      if (seq_ctl.start) begin
         cnt_in = '0;
      end
      if (adv && uc.lever_en) begin
         lo_in = $signed({1'b0, lever_ff}) * opnd_om_ff;
      end
      if (adv && uc.loop_en) begin
         acc_in  = x_ext + (sgn[1] ? -y_ext : y_ext) + (sgn[0] ? -lo_ext : lo_ext);
         prod_in = acc_ff * $signed({1'b0, ir_ff});
         cnt_in  = CNT_W'(cnt_ff + 3'd1);
         if (cnt_ff >= 3'd2) begin
            wheel_in[wr_idx] = rnd;
         end
      end
   end

   // Result assembly
   assign pmask = preset_neg(cmd_ff);
   assign p16   = {1'b0, preset_ff};
   assign n16   = WHEEL_W'(-p16);

   always_comb begin
      case (uc.emit_src)
         SRC_PRESET: begin
            for (int k = 0; k < 4; k++) begin
               emit_w[k] = pmask[k] ? n16 : p16;
            end
         end
         SRC_MIX:  emit_w = {rnd, wheel_ff[2], wheel_ff[1], wheel_ff[0]};
         default:  emit_w = '0;
      endcase
      rsp_data_in   = emit_fire ? emit_w : rsp_data_ff;
      if (emit_fire) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_fire) begin
         rsp_tvalid_in = 1'b0;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= SPEED_STEP_RST;
         limit_ff      <= SPEED_LIMIT_RST;
         preset_ff     <= PRESET_SPEED_RST;
         ir_ff         <= INV_RADIUS_RST;
         lever_ff      <= LEVER_ARM_RST;
         stored_vx_ff  <= '0;
         stored_vy_ff  <= '0;
         stored_om_ff  <= '0;
         cnt_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         step_ff       <= step_in;
         limit_ff      <= limit_in;
         preset_ff     <= preset_in;
         ir_ff         <= ir_in;
         lever_ff      <= lever_in;
         stored_vx_ff  <= stored_vx_in;
         stored_vy_ff  <= stored_vy_in;
         stored_om_ff  <= stored_om_in;
         cnt_ff        <= cnt_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      opnd_vx_ff  <= opnd_vx_in;
      opnd_vy_ff  <= opnd_vy_in;
      opnd_om_ff  <= opnd_om_in;
      lo_ff       <= lo_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      wheel_ff    <= wheel_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Checks
   `MVM_ASSERT_NXT(a_start_busy, req_fire && (req_tuser <= CMD_DIRECT), seq_stat.busy, "command accepted but program not started")
   `MVM_ASSERT_IMP(a_stored_range, 1'b1, (stored_vx_ff != 16'sh8000) && (stored_vy_ff != 16'sh8000) && (stored_om_ff != 16'sh8000), "stored velocity beyond clamp range")
   `MVM_ASSERT_IMP(a_loop_count, uc.loop_en, cnt_ff <= LOOP_LAST, "wheel loop overran")
   `MVM_ASSERT_NXT(a_emit_valid, emit_fire, rsp_tvalid_ff, "emitted result not presented")

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the mecanum velocity mixer: directed and random commands.
`timescale 1ns / 1ps

module tb_top;
   import mvm_pkg::*;

   // Commands 14 and 15 are dropped by the block, no wheel transaction comes back
   localparam logic [3:0] CMD_SPARE_LO = 4'd14;
   localparam logic [3:0] CMD_SPARE_HI = 4'd15;
   // Register index outside the map, a write to it must change nothing
   localparam logic [2:0] REG_NONE     = 3'd7;

   // Cycles let pass after the last wheel transaction before a register write
   localparam int SETTLE_CYCLES  = 20;
   // Long receiver hold-off, so the block fills up and stalls its command input
   localparam int HOLD_CYCLES    = 150;
   localparam int ITEMS_PER_PASS = 235;
   localparam int NUM_PASSES     = 8;

   // One wheel transaction, front left in the lowest bits as on rsp_tdata
   typedef struct packed {
      logic signed [15:0] rr;
      logic signed [15:0] rl;
      logic signed [15:0] fr;
      logic signed [15:0] fl;
   } wheel_set_type;

   // Mixer predictor with its own copy of the registers and the stored velocities;
   // holds the queue of wheel transactions still to come.
   class mixer_scoreboard;
      int speed_step;
      int speed_limit;
      int preset_speed;
      int inv_radius;
      int lever_arm;
      int vx_st;
      int vy_st;
      int om_st;
      wheel_set_type wheels_due[$];
      int mismatch_count;

      function new();
         speed_step     = int'(SPEED_STEP_RST);
         speed_limit    = int'(SPEED_LIMIT_RST);
         preset_speed   = int'(PRESET_SPEED_RST);
         inv_radius     = int'(INV_RADIUS_RST);
         lever_arm      = int'(LEVER_ARM_RST);
         vx_st          = 0;
         vy_st          = 0;
         om_st          = 0;
         mismatch_count = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [15:0] d);
         case (idx)
            REG_SPEED_STEP:   speed_step   = int'(d[12:0]);
            REG_SPEED_LIMIT:  speed_limit  = int'(d[14:0]);
            REG_PRESET_SPEED: preset_speed = int'(d[14:0]);
            REG_INV_RADIUS:   inv_radius   = int'(d[7:0]);
            REG_LEVER_ARM:    lever_arm    = int'(d[12:0]);
            default: ;
         endcase
      endfunction

      // Q24 sum times gain, rounded to Q8 with floor, saturated to 16 bits
      function logic signed [15:0] wheel_speed(longint sum_q24);
         longint prod;
         longint rounded;
         prod    = sum_q24 * longint'(inv_radius);
         rounded = (prod + 64'sd32768) >>> 16;
         if (rounded > 32767)
            rounded = 32767;
         else if (rounded < -32768)
            rounded = -32768;
         return rounded[15:0];
      endfunction

      function wheel_set_type mix_wheels(int vx, int vy, int om);
         longint x;
         longint y;
         longint lo;
         wheel_set_type w;
         x    = longint'(vx) * 4096;
         y    = longint'(vy) * 4096;
         lo   = longint'(lever_arm) * longint'(om);
         w.fl = wheel_speed(x + y + lo);
         w.fr = wheel_speed(x - y - lo);
         w.rl = wheel_speed(x - y + lo);
         w.rr = wheel_speed(x + y - lo);
         return w;
      endfunction

      // Clamp only on the side of the step
      function int step_up(int v);
         int n;
         n = v + speed_step;
         return (n > speed_limit) ? speed_limit : n;
      endfunction

      function int step_down(int v);
         int n;
         n = v - speed_step;
         return (n < -speed_limit) ? -speed_limit : n;
      endfunction

      function void push_preset(logic [3:0] neg_mask);
         logic signed [15:0] pos;
         wheel_set_type w;
         pos  = 16'(preset_speed);
         w.fl = neg_mask[0] ? -pos : pos;
         w.fr = neg_mask[1] ? -pos : pos;
         w.rl = neg_mask[2] ? -pos : pos;
         w.rr = neg_mask[3] ? -pos : pos;
         wheels_due.push_back(w);
      endfunction

      // Called for every accepted command transaction
      function void note_command(logic [3:0] cmd, logic [47:0] d);
         case (cmd)
            CMD_CLEAR: begin
               vx_st = 0;
               vy_st = 0;
               om_st = 0;
               wheels_due.push_back('0);
            end
            CMD_FWD:        push_preset(4'b0000);
            CMD_BACK:       push_preset(4'b1111);
            CMD_TURN_L:     push_preset(4'b0101);
            CMD_TURN_R:     push_preset(4'b1010);
            CMD_STRAFE_L:   push_preset(4'b0110);
            CMD_STRAFE_R:   push_preset(4'b1001);
            CMD_STEP_VX_UP: vx_st = step_up(vx_st);
            CMD_STEP_VX_DN: vx_st = step_down(vx_st);
            CMD_STEP_OM_UP: om_st = step_up(om_st);
            CMD_STEP_OM_DN: om_st = step_down(om_st);
            CMD_STEP_VY_UP: vy_st = step_up(vy_st);
            CMD_STEP_VY_DN: vy_st = step_down(vy_st);
            CMD_DIRECT: begin
               wheels_due.push_back(mix_wheels(int'($signed(d[15:0])),
                                               int'($signed(d[31:16])),
                                               int'($signed(d[47:32]))));
            end
            default: ;
         endcase
         if (cmd >= CMD_STEP_VX_UP && cmd <= CMD_STEP_VY_DN)
            wheels_due.push_back(mix_wheels(vx_st, vy_st, om_st));
      endfunction

      function void compare_field(string name, logic signed [15:0] want,
                                  logic signed [15:0] got);
         if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
         end
      endfunction

      // Called for every accepted wheel transaction
      function void check_wheels(logic [63:0] d);
         wheel_set_type got;
         wheel_set_type want;
         got = d;
         if (wheels_due.size() == 0) begin
            $error("wheel transaction with none outstanding: %h", d);
            mismatch_count++;
         end else begin
            want = wheels_due.pop_front();
            compare_field("wheel_front_left",  want.fl, got.fl);
            compare_field("wheel_front_right", want.fr, got.fr);
            compare_field("wheel_rear_left",   want.rl, got.rl);
            compare_field("wheel_rear_right",  want.rr, got.rr);
         end
      endfunction

      function int pending();
         return wheels_due.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;    // move_vx, move_vy, move_omega
   logic [REQ_USER_W-1:0]  req_tuser = '0;    // cmd
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;         // front left, front right, rear left, rear right
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // Idling switches and the hold-off request (single writer each)
   bit tx_idle_on = 1'b1;
   bit rx_idle_on = 1'b1;
   int holds_asked = 0;

   mixer_scoreboard sb = new();

   mecanum_velocity_mixer_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 4 ns clock
   initial begin
      forever #2 clock = ~clock;
   end

   // Wheel transactions are sampled at the rising edge, before the block updates
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_wheels(rsp_tdata);
   end

   // Receiver: random idle bursts, and the long hold-off when asked.
   // The hold-off is counted here; holds_asked is only read.
   initial begin : wheel_sink
      int idle_left;
      int hold_left;
      int holds_done;
      idle_left  = 0;
      hold_left  = 0;
      holds_done = 0;
      forever begin
         @(negedge clock);
         if (holds_done != holds_asked) begin
            holds_done = holds_asked;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (idle_left > 0) begin
            idle_left--;
            rsp_tready <= 1'b0;
         end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
            idle_left = $urandom_range(0, 2);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Offer one command transaction and wait for it to be taken. tvalid is left
   // high, so the next command follows back to back unless an idle burst comes.
   task automatic send_cmd(input logic [3:0] cmd, input logic [47:0] d);
      @(negedge clock);
      if (tx_idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      sb.note_command(cmd, d);
   endtask

   // Drop tvalid and wait until every outstanding wheel transaction is in
   task automatic drain_wheels();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] d);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, d);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Rewrite every register once the block is idle. Bits above each register's
   // width are filled at random; the block must ignore them.
   task automatic configure(input int step, input int limit, input int preset,
                            input int inv_r, input int lever);
      logic [15:0] junk;
      drain_wheels();
      // dropped commands can still be in flight with nothing outstanding
      repeat (SETTLE_CYCLES) @(posedge clock);
      junk = 16'($urandom);
      write_reg(REG_SPEED_STEP,   16'(step)   | (junk & 16'hE000));
      write_reg(REG_SPEED_LIMIT,  16'(limit)  | (junk & 16'h8000));
      write_reg(REG_PRESET_SPEED, 16'(preset) | (junk & 16'h8000));
      write_reg(REG_INV_RADIUS,   16'(inv_r)  | (junk & 16'hFF00));
      write_reg(REG_LEVER_ARM,    16'(lever)  | (junk & 16'hE000));
   endtask

   function automatic logic [47:0] pack_move(int vx, int vy, int om);
      return {16'(om), 16'(vy), 16'(vx)};
   endfunction

   function automatic int pick_velocity();
      case ($urandom_range(0, 5))
         0:       return 32767;
         1:       return -32768;
         2:       return 0;
         default: return int'($signed(16'($urandom)));
      endcase
   endfunction

   // Full-range random moves half the time, joystick-sized moves and corner values the rest
   function automatic logic [47:0] random_move();
      case ($urandom_range(0, 3))
         0: return pack_move($urandom_range(0, 4000) - 2000,
                             $urandom_range(0, 4000) - 2000,
                             $urandom_range(0, 4000) - 2000);
         1: return pack_move(pick_velocity(), pick_velocity(), pick_velocity());
         default: return 48'({$urandom, $urandom});
      endcase
   endfunction

   // Step commands dominate so the stored velocities walk into the clamps;
   // the odd clear brings them back
   function automatic logic [3:0] random_cmd();
      int r;
      r = $urandom_range(0, 99);
      if (r < 3)
         return CMD_CLEAR;
      else if (r < 15)
         return 4'($urandom_range(CMD_FWD, CMD_STRAFE_R));
      else if (r < 65)
         return 4'($urandom_range(CMD_STEP_VX_UP, CMD_STEP_VY_DN));
      else if (r < 97)
         return CMD_DIRECT;
      else
         return ($urandom_range(0, 1) == 0) ? CMD_SPARE_LO : CMD_SPARE_HI;
   endfunction

   // Register settings per pass: speed_step, speed_limit, preset_speed, inverse_radius,
   // lever_arm. Defaults, maxima, minima, zero gain, mixed, random, mixed, then defaults.
   int pass_step[NUM_PASSES]   = '{205, 8191, 0, 4096, 1, 0, 300, 205};
   int pass_limit[NUM_PASSES]  = '{1229, 32767, 0, 300, 32767, 0, 2000, 1229};
   int pass_preset[NUM_PASSES] = '{1024, 32767, 0, 500, 1, 0, 20000, 1024};
   int pass_inv_r[NUM_PASSES]  = '{20, 255, 1, 0, 128, 0, 200, 20};
   int pass_lever[NUM_PASSES]  = '{1581, 8191, 0, 4000, 1, 0, 6000, 1581};

   initial begin : stimulus
      int sent;
      logic [3:0] cmd;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: every command under the reset settings, the clamp on vx,
      // direct moves at the field extremes, and the two dropped codes
      send_cmd(CMD_CLEAR, 48'hFFFF_FFFF_FFFF);
      for (int c = CMD_FWD; c <= CMD_STRAFE_R; c++)
         send_cmd(4'(c), 48'({$urandom, $urandom}));
      repeat (6) send_cmd(CMD_STEP_VX_UP, 48'h0);   // sixth step hits the limit
      send_cmd(CMD_STEP_VX_DN, 48'h0);
      send_cmd(CMD_STEP_OM_UP, 48'h0);
      send_cmd(CMD_STEP_OM_DN, 48'h0);
      send_cmd(CMD_STEP_VY_UP, 48'h0);
      send_cmd(CMD_STEP_VY_DN, 48'h0);
      send_cmd(CMD_DIRECT, pack_move(32767, 32767, 32767));
      send_cmd(CMD_DIRECT, pack_move(-32768, -32768, -32768));
      send_cmd(CMD_DIRECT, pack_move(32767, -32768, 32767));
      send_cmd(CMD_DIRECT, pack_move(0, 0, 0));
      send_cmd(CMD_SPARE_LO, 48'hFFFF_FFFF_FFFF);
      send_cmd(CMD_SPARE_HI, 48'h0);
      send_cmd(CMD_STEP_VY_UP, 48'h0);

      // Random passes. The stored velocities carry over from one pass to the next,
      // so a lowered limit meets values beyond it on the opposite side.
      for (int p = 0; p < NUM_PASSES; p++) begin
         configure(pass_step[p], pass_limit[p], pass_preset[p], pass_inv_r[p],
                   pass_lever[p]);
         if (p == 0)
            write_reg(REG_NONE, 16'hFFFF);
         if (p == 5)
            configure($urandom_range(0, 8191), $urandom_range(0, 32767),
                      $urandom_range(0, 32767), $urandom_range(1, 255),
                      $urandom_range(0, 8191));
         sent = 0;
         while (sent < ITEMS_PER_PASS) begin
            if (p == NUM_PASSES - 1) begin
               tx_idle_on = 1'b0;
               rx_idle_on = 1'b0;
            end else if (sent % 40 == 0) begin
               tx_idle_on = ($urandom_range(0, 3) != 0);
               rx_idle_on = ($urandom_range(0, 3) != 0);
            end
            // receiver holds off while commands keep coming
            if (p == 1 && sent == 50)
               holds_asked++;
            // sender pauses until the pipeline is empty
            if (p == 4 && sent == 100)
               drain_wheels();
            cmd = random_cmd();
            send_cmd(cmd, random_move());
            if (cmd != CMD_SPARE_LO && cmd != CMD_SPARE_HI)
               sent++;
         end
      end

      drain_wheels();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // Watchdog, far beyond the slowest correct run
   initial begin : watchdog
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl
rtl/mvm_pkg.sv
rtl/mvm_seq.sv
rtl/mecanum_velocity_mixer_top.sv
sim/tb_top.sv
